[sv/bsim_pkg.sv]
// Shared types and constants for the bank-switching IRQ mapper.
// No dependencies; every other file of the block depends on this package.
package bsim_pkg;

  // Field widths of the channel payloads
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned TICK_W  = 3;
  localparam int unsigned ROM_W   = 21;
  localparam int unsigned PAGE_W  = 9;

  // Defaults
  localparam int unsigned TICK_DIVIDER_DEF = 3;
  localparam logic [PAGE_W-1:0] PAGE_COUNT_RST = 9'd32;

  // Reset values of the program bank registers
  localparam logic [7:0] PRG0_RST = 8'h00;
  localparam logic [7:0] PRG1_RST = 8'h01;
  localparam logic [7:0] PRG2_RST = 8'hFE;

  // Item operations
  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 2'd0,
    OP_TICK     = 2'd1,
    OP_PRG_READ = 2'd2,
    OP_CHR_READ = 2'd3
  } op_t;

  // Write decode: address bits 15..12
  localparam logic [3:0] REG_PRG0 = 4'h8;
  localparam logic [3:0] REG_CTRL = 4'h9;
  localparam logic [3:0] REG_PRG1 = 4'hA;
  localparam logic [3:0] REG_CHR  = 4'hB;
  localparam logic [3:0] REG_PRG2 = 4'hC;

  // Control register sub-addresses (address bits 2..0)
  localparam logic [2:0] SUB_MIRROR = 3'd1;
  localparam logic [2:0] SUB_IRQ_EN = 3'd3;
  localparam logic [2:0] SUB_RELOAD = 3'd4;
  localparam logic [2:0] SUB_HIGH   = 3'd5;
  localparam logic [2:0] SUB_LOW    = 3'd6;

  // One input item as held in the input register
  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] value;
    logic [TICK_W-1:0] tick_count;
  } item_t;

  // Bank state handed from the register file to the address translator
  typedef struct packed {
    logic [2:0][7:0]    prg_bank;
    logic [7:0][7:0]    chr_bank;
    logic [PAGE_W-1:0]  page_count;
  } banks_t;

endpackage

[sv/bsim_in_if.sv]
// Input channel of the mapper: valid/ready handshake with the item fields.
// Depends on bsim_pkg for the field widths.
interface bsim_in_if;
  logic                           valid;
  logic                           ready;
  logic [bsim_pkg::OP_W-1:0]      operation;
  logic [bsim_pkg::ADDR_W-1:0]    address;
  logic [bsim_pkg::DATA_W-1:0]    value;
  logic [bsim_pkg::TICK_W-1:0]    tick_count;

  modport source (output valid, operation, address, value, tick_count, input ready);
  modport sink   (input valid, operation, address, value, tick_count, output ready);
endinterface

[sv/bsim_out_if.sv]
// Result channel of the mapper: valid/ready handshake with the result fields.
// Depends on bsim_pkg for the field widths.
interface bsim_out_if;
  logic                        valid;
  logic                        ready;
  logic                        irq_line;
  logic                        mirror_mode;
  logic [bsim_pkg::ROM_W-1:0]  rom_address;

  modport source (output valid, irq_line, mirror_mode, rom_address, input ready);
  modport sink   (input valid, irq_line, mirror_mode, rom_address, output ready);
endinterface

[sv/bsim_cfg_if.sv]
// Configuration write channel: carries the program page count.
// Depends on bsim_pkg for the register width.
interface bsim_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bsim_pkg::PAGE_W-1:0]  prg_page_count;

  modport source (output valid, prg_page_count, input ready);
  modport sink   (input valid, prg_page_count, output ready);
endinterface

[sv/bsim_state.sv]
// Mapper register file: bank registers, mirroring, IRQ reload and down-counter.
// Applies one item per advancing cycle. Depends on bsim_pkg.
module bsim_state #(
  parameter int unsigned TICK_DIVIDER = bsim_pkg::TICK_DIVIDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  bsim_pkg::item_t             item,
  input  logic                        cfg_we,
  input  logic [bsim_pkg::PAGE_W-1:0] cfg_data,
  output bsim_pkg::banks_t            banks,
  output logic                        irq_nxt_o,
  output logic                        mirror_nxt_o
);
  import bsim_pkg::*;

  // Phase holds values below the divider; the sum of phase and ticks fits in four bits
  localparam int unsigned PH_W      = $clog2(TICK_DIVIDER + 1);
  localparam int unsigned SUM_W     = 4;
  localparam int unsigned MAX_STEPS = (TICK_DIVIDER - 1 + 7) / TICK_DIVIDER;
  localparam logic [SUM_W-1:0] DIV_L = SUM_W'(TICK_DIVIDER);

  logic [2:0][7:0]   prg_bank_r, prg_bank_nxt;
  logic [7:0][7:0]   chr_bank_r, chr_bank_nxt;
  logic [PAGE_W-1:0] page_count_r;
  logic              mirror_r, mirror_nxt;
  logic [15:0]       counter_r, counter_nxt;
  logic [7:0]        reload_high_r, reload_high_nxt;
  logic [7:0]        reload_low_r, reload_low_nxt;
  logic              irq_en_r, irq_en_nxt;
  logic              irq_r, irq_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  dec;

  // Closed form of the tick group: count how many divider periods elapse
  always_comb begin
    rem = SUM_W'(phase_r) + SUM_W'(item.tick_count);
    dec = '0;
    for (int i = 0; i < MAX_STEPS; i++) begin
      if (rem >= DIV_L) begin
        rem = rem - DIV_L;
        dec = dec + SUM_W'(1);
      end
    end
  end

  // Next state for the item at the head of the pipeline
  always_comb begin
    prg_bank_nxt    = prg_bank_r;
    chr_bank_nxt    = chr_bank_r;
    mirror_nxt      = mirror_r;
    counter_nxt     = counter_r;
    reload_high_nxt = reload_high_r;
    reload_low_nxt  = reload_low_r;
    irq_en_nxt      = irq_en_r;
    irq_nxt         = irq_r;
    phase_nxt       = phase_r;
    case (item.operation)
      OP_WRITE: begin
        case (item.address[15:12])
          REG_PRG0: prg_bank_nxt[0] = item.value;
          REG_PRG1: prg_bank_nxt[1] = item.value;
          REG_PRG2: prg_bank_nxt[2] = item.value;
          REG_CHR:  chr_bank_nxt[item.address[2:0]] = item.value;
          REG_CTRL: begin
            case (item.address[2:0])
              SUB_MIRROR: mirror_nxt = item.value[7];
              SUB_IRQ_EN: begin
                irq_en_nxt = item.value[7];
                irq_nxt    = 1'b0;
              end
              SUB_RELOAD: begin
                counter_nxt = {reload_high_r, reload_low_r};
                irq_nxt     = 1'b0;
              end
              SUB_HIGH: reload_high_nxt = item.value;
              SUB_LOW:  reload_low_nxt  = item.value;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (irq_en_r) begin
          phase_nxt = rem[PH_W-1:0];
          // A nonzero counter stops at zero and raises the request there
          if (counter_r != 16'd0 && dec != '0) begin
            if (16'(dec) >= counter_r) begin
              counter_nxt = 16'd0;
              irq_nxt     = 1'b1;
            end else begin
              counter_nxt = counter_r - 16'(dec);
            end
          end
        end
      end
      default: ;
    endcase
  end

  // State registers move only when the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_r    <= {PRG2_RST, PRG1_RST, PRG0_RST};
      chr_bank_r    <= '0;
      mirror_r      <= 1'b0;
      counter_r     <= '0;
      reload_high_r <= '0;
      reload_low_r  <= '0;
      irq_en_r      <= 1'b0;
      irq_r         <= 1'b0;
      phase_r       <= '0;
    end else if (advance) begin
      prg_bank_r    <= prg_bank_nxt;
      chr_bank_r    <= chr_bank_nxt;
      mirror_r      <= mirror_nxt;
      counter_r     <= counter_nxt;
      reload_high_r <= reload_high_nxt;
      reload_low_r  <= reload_low_nxt;
      irq_en_r      <= irq_en_nxt;
      irq_r         <= irq_nxt;
      phase_r       <= phase_nxt;
    end
  end

  // Page count register, written from the configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= PAGE_COUNT_RST;
    end else if (cfg_we) begin
      page_count_r <= cfg_data;
    end
  end

  assign banks.prg_bank   = prg_bank_r;
  assign banks.chr_bank   = chr_bank_r;
  assign banks.page_count = page_count_r;
  assign irq_nxt_o        = irq_nxt;
  assign mirror_nxt_o     = mirror_nxt;

endmodule

[sv/bsim_xlate.sv]
// Read address translation: program and character windows to ROM byte address.
// Purely combinational. Depends on bsim_pkg.
module bsim_xlate (
  input  bsim_pkg::item_t            item,
  input  bsim_pkg::banks_t           banks,
  output logic [bsim_pkg::ROM_W-1:0] rom_address
);
  import bsim_pkg::*;

  logic [1:0]  window;
  logic [7:0]  prg_sel;
  logic [8:0]  last_page;
  logic [7:0]  chr_sel;

  // The top window is tied to the final page; the others follow their registers
  always_comb begin
    window    = item.address[14:13];
    last_page = banks.page_count - PAGE_W'(1);
    if (window == 2'd3) begin
      prg_sel = last_page[7:0];
    end else begin
      prg_sel = banks.prg_bank[window];
    end
    chr_sel = banks.chr_bank[item.address[12:10]];
  end

  // Writes and ticks report zero, as do reads outside the mapped windows
  always_comb begin
    case (item.operation)
      OP_PRG_READ: begin
        if (item.address[15]) begin
          rom_address = {prg_sel, item.address[12:0]};
        end else begin
          rom_address = '0;
        end
      end
      OP_CHR_READ: begin
        if (item.address[15:13] == 3'd0) begin
          rom_address = {3'd0, chr_sel, item.address[9:0]};
        end else begin
          rom_address = '0;
        end
      end
      default: rom_address = '0;
    endcase
  end

endmodule

[sv/bank_switch_irq_mapper_core.sv]
// Top level of the bank-switching IRQ mapper. Depends on bsim_pkg, the three
// channel interfaces, bsim_state and bsim_xlate.
//
// The core takes one item per clock and returns exactly one result beat per
// item, in order. An accepted item sits in the input register, is applied to
// the mapper registers and lands in the result register; the core sustains one
// item per cycle, stalling only while the result register holds an untaken
// beat. The tick divider loop is resolved combinationally, and the
// configuration port is always ready; write it only while the core is idle.
module bank_switch_irq_mapper_core #(
  parameter int unsigned TICK_DIVIDER = bsim_pkg::TICK_DIVIDER_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  bsim_in_if.sink        in_ch,
  bsim_out_if.source     out_ch,
  bsim_cfg_if.sink       cfg_ch
);
  import bsim_pkg::*;

  logic                in_v_r;
  item_t               in_item_r;
  logic                out_v_r;
  logic                out_irq_r;
  logic                out_mirror_r;
  logic [ROM_W-1:0]    out_rom_r;

  logic                advance;
  banks_t              banks;
  logic                irq_nxt;
  logic                mirror_nxt;
  logic [ROM_W-1:0]    rom_address;

  // Item advances whenever the result register is free or being emptied
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign cfg_ch.ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.operation  <= op_t'(in_ch.operation);
      in_item_r.address    <= in_ch.address;
      in_item_r.value      <= in_ch.value;
      in_item_r.tick_count <= in_ch.tick_count;
    end
  end

  bsim_state #(
    .TICK_DIVIDER (TICK_DIVIDER)
  ) u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .item         (in_item_r),
    .cfg_we       (cfg_ch.valid && cfg_ch.ready),
    .cfg_data     (cfg_ch.prg_page_count),
    .banks        (banks),
    .irq_nxt_o    (irq_nxt),
    .mirror_nxt_o (mirror_nxt)
  );

  bsim_xlate u_xlate (
    .item        (in_item_r),
    .banks       (banks),
    .rom_address (rom_address)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_irq_r    <= irq_nxt;
      out_mirror_r <= mirror_nxt;
      out_rom_r    <= rom_address;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.irq_line    = out_irq_r;
  assign out_ch.mirror_mode = out_mirror_r;
  assign out_ch.rom_address = out_rom_r;

endmodule

[sv/bsim_checker.sv]
// Port-level checks for the mapper core, and the bind that attaches them.
// Depends on bsim_pkg and bank_switch_irq_mapper_core.
module bsim_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        irq_line,
  input logic                        mirror_mode,
  input logic [bsim_pkg::ROM_W-1:0]  rom_address
);
  import bsim_pkg::*;

  // No result beat is offered straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input back-pressure only ever comes from a stalled result beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled result beat");

  // A stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(irq_line)
      && $stable(mirror_mode) && $stable(rom_address))
    else $error("stalled result beat changed");

  // An offered input is taken whenever the result side is draining
  a_take_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input refused while results drain");

endmodule

bind bank_switch_irq_mapper_core bsim_checker u_bsim_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .irq_line    (out_ch.irq_line),
  .mirror_mode (out_ch.mirror_mode),
  .rom_address (out_ch.rom_address)
);

[dv/tb_top.sv]
// Self-checking testbench for bank_switch_irq_mapper_core: directed and random items,
// with every result compared against a behavioural mapper model in this module.
// Depends on bsim_pkg, the three channel interfaces and bank_switch_irq_mapper_core.
module tb_top;
  import bsim_pkg::*;

  // Run limits, in cycles, for draining and settling
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One result beat as the mapper should produce it
  typedef struct packed {
    logic             irq;
    logic             mirror;
    logic [ROM_W-1:0] rom;
  } mapper_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bsim_in_if  in_ch();
  bsim_out_if out_ch();
  bsim_cfg_if cfg_ch();

  bank_switch_irq_mapper_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mapper model state
  logic [7:0]        prg_sel [3];
  logic [7:0]        chr_sel [8];
  logic              mirror_h;
  logic [15:0]       irq_count;
  logic [7:0]        latch_hi;
  logic [7:0]        latch_lo;
  logic              irq_armed;
  logic              irq_flag;
  logic [1:0]        tick_acc;
  logic [PAGE_W-1:0] page_total;

  mapper_result_t mapper_results [$];
  mapper_result_t checked_want;
  int unsigned    mismatch_count = 0;
  int unsigned    live_items = 0;
  int unsigned    send_gap_pct = 0;
  int unsigned    recv_stall_pct = 0;

  // Clock: period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  // Applies one item to the model and returns the result beat it causes.
  function automatic mapper_result_t mapper_step(input item_t it);
    mapper_result_t    r;
    int unsigned       acc;
    logic [PAGE_W-1:0] last_page;
    logic [7:0]        bank;
    r.rom = '0;
    case (it.operation)
      OP_WRITE: begin
        case (it.address[15:12])
          REG_PRG0: prg_sel[0] = it.value;
          REG_PRG1: prg_sel[1] = it.value;
          REG_PRG2: prg_sel[2] = it.value;
          REG_CHR:  chr_sel[it.address[2:0]] = it.value;
          REG_CTRL: begin
            case (it.address[2:0])
              SUB_MIRROR: mirror_h = it.value[7];
              SUB_IRQ_EN: begin
                irq_armed = it.value[7];
                irq_flag  = 1'b0;
              end
              SUB_RELOAD: begin
                irq_count = {latch_hi, latch_lo};
                irq_flag  = 1'b0;
              end
              SUB_HIGH: latch_hi = it.value;
              SUB_LOW:  latch_lo = it.value;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        // The phase is held while the counter is disabled.
        if (irq_armed) begin
          acc = tick_acc + it.tick_count;
          while (acc >= TICK_DIVIDER_DEF) begin
            acc -= TICK_DIVIDER_DEF;
            if (irq_count != 16'd0) begin
              irq_count = irq_count - 16'd1;
              if (irq_count == 16'd0)
                irq_flag = 1'b1;
            end
          end
          tick_acc = acc[1:0];
        end
      end
      OP_PRG_READ: begin
        if (it.address[15]) begin
          last_page = page_total - 1'b1;
          bank = (it.address[14:13] == 2'd3) ? last_page[7:0] : prg_sel[it.address[14:13]];
          r.rom = {bank, it.address[12:0]};
        end
      end
      default: begin
        if (it.address[15:13] == 3'd0)
          r.rom = ROM_W'({chr_sel[it.address[12:10]], it.address[9:0]});
      end
    endcase
    r.irq    = irq_flag;
    r.mirror = mirror_h;
    return r;
  endfunction

  // Sends one item, with random idle cycles ahead of it, and records its result.
  task automatic send_item(input item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.operation  <= OP_W'($urandom);
      in_ch.address    <= ADDR_W'($urandom);
      in_ch.value      <= DATA_W'($urandom);
      in_ch.tick_count <= TICK_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= it.operation;
    in_ch.address    <= it.address;
    in_ch.value      <= it.value;
    in_ch.tick_count <= it.tick_count;
    do @(posedge clk); while (!in_ch.ready);
    mapper_results.push_back(mapper_step(it));
    // Writes to unused addresses do nothing, so they are not counted.
    if (it.operation != OP_WRITE)
      live_items++;
    else if (it.address[15:12] inside {REG_PRG0, REG_PRG1, REG_PRG2, REG_CHR})
      live_items++;
    else if (it.address[15:12] == REG_CTRL &&
             it.address[2:0] inside {SUB_MIRROR, SUB_IRQ_EN, SUB_RELOAD, SUB_HIGH, SUB_LOW})
      live_items++;
  endtask

  task automatic send_fields(input op_t op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] val, input logic [TICK_W-1:0] ticks);
    item_t it;
    it.operation  = op;
    it.address    = addr;
    it.value      = val;
    it.tick_count = ticks;
    send_item(it);
  endtask

  // Control register write; the address bits that are not decoded are random.
  task automatic ctrl_write(input logic [2:0] sub, input logic [DATA_W-1:0] val);
    send_fields(OP_WRITE, {REG_CTRL, 9'($urandom), sub}, val, TICK_W'($urandom));
  endtask

  // Holds the sender back until every outstanding result beat has been taken.
  task automatic wait_for_results();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (mapper_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (mapper_results.size() != 0) begin
      report_mismatch("results never arrived, count", mapper_results.size(), 0);
      mapper_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_page_count(input logic [PAGE_W-1:0] count);
    wait_for_results();
    @(negedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.prg_page_count <= count;
    do @(posedge clk); while (!cfg_ch.ready);
    page_total = count;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random item: mostly register writes and in-range reads, some noise.
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    it.operation  = op_t'($urandom_range(0, 3));
    it.address    = ADDR_W'($urandom);
    it.value      = DATA_W'($urandom);
    it.tick_count = TICK_W'($urandom);
    pick = $urandom_range(0, 9);
    case (it.operation)
      OP_WRITE: begin
        if (pick < 8) begin
          case ($urandom_range(0, 4))
            0: it.address[15:12] = REG_PRG0;
            1: it.address[15:12] = REG_PRG1;
            2: it.address[15:12] = REG_PRG2;
            3: it.address[15:12] = REG_CHR;
            default: it.address[15:12] = REG_CTRL;
          endcase
        end
        // Keep the reload value mostly small so the counter can run out.
        if (it.address[15:12] == REG_CTRL && it.address[2:0] == SUB_HIGH && pick < 6)
          it.value = 8'h00;
      end
      OP_PRG_READ: if (pick < 8) it.address[15] = 1'b1;
      OP_CHR_READ: if (pick < 8) it.address[15:13] = 3'd0;
      default: ;
    endcase
    return it;
  endfunction

  // Programs the counter, usually arms it and runs a burst of ticks with a few other items.
  task automatic send_irq_program();
    int unsigned burst;
    burst = $urandom_range(4, 30);
    ctrl_write(SUB_HIGH, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
    ctrl_write(SUB_LOW, 8'($urandom_range(0, 40)));
    ctrl_write(SUB_RELOAD, 8'($urandom));
    ctrl_write(SUB_IRQ_EN, {($urandom_range(0, 7) != 0), 7'($urandom)});
    repeat (burst) begin
      if ($urandom_range(0, 4) == 0)
        send_item(random_item());
      else
        send_fields(OP_TICK, ADDR_W'($urandom), DATA_W'($urandom), TICK_W'($urandom));
    end
  endtask

  // Translations straight after reset, with the default page count.
  task automatic test_reset_defaults();
    send_fields(OP_PRG_READ, 16'h8000, 8'h00, 3'd0);
    send_fields(OP_PRG_READ, 16'hFFFF, 8'hFF, 3'd7);
    send_fields(OP_PRG_READ, 16'h7FFF, 8'h00, 3'd0);
  endtask

  // Bank registers at their extremes, reads out of range and unused write addresses.
  task automatic test_bank_windows();
    send_fields(OP_WRITE, 16'h8000, 8'hFF, 3'd0);
    send_fields(OP_PRG_READ, 16'h9FFF, 8'h00, 3'd0);
    send_fields(OP_WRITE, 16'hB007, 8'hFF, 3'd0);
    send_fields(OP_CHR_READ, 16'h1FFF, 8'h00, 3'd0);
    send_fields(OP_CHR_READ, 16'h2000, 8'h00, 3'd0);
    send_fields(OP_WRITE, 16'h7FFF, 8'hFF, 3'd7);
    send_fields(OP_WRITE, 16'hD000, 8'hFF, 3'd7);
    send_fields(OP_WRITE, 16'h9007, 8'hFF, 3'd7);
  endtask

  // Mirroring, disabled ticks, countdown to zero, ticks at zero and acknowledge.
  task automatic test_irq_counter();
    ctrl_write(SUB_MIRROR, 8'h80);
    ctrl_write(SUB_HIGH, 8'h00);
    ctrl_write(SUB_LOW, 8'h02);
    send_fields(OP_TICK, 16'h0000, 8'h00, 3'd7);
    ctrl_write(SUB_RELOAD, 8'h00);
    ctrl_write(SUB_IRQ_EN, 8'h80);
    send_fields(OP_TICK, 16'hFFFF, 8'hFF, 3'd7);
    send_fields(OP_TICK, 16'h0000, 8'h00, 3'd7);
    ctrl_write(SUB_IRQ_EN, 8'h80);
    ctrl_write(SUB_MIRROR, 8'h00);
    send_fields(OP_TICK, 16'h0000, 8'h00, 3'd0);
  endtask

  // Fixed window with the smallest, largest and out-of-range page counts.
  task automatic test_page_count_extremes();
    write_page_count(9'd1);
    send_fields(OP_PRG_READ, 16'hE000, 8'h00, 3'd0);
    write_page_count(9'd256);
    send_fields(OP_PRG_READ, 16'hE000, 8'h00, 3'd0);
    write_page_count(9'd0);
    send_fields(OP_PRG_READ, 16'hE000, 8'h00, 3'd0);
    write_page_count(9'd511);
    send_fields(OP_PRG_READ, 16'hE000, 8'h00, 3'd0);
  endtask

  // One phase of random traffic under one idling pattern and page count.
  task automatic test_random_traffic(input idle_mode_t mode, input logic [PAGE_W-1:0] count,
                                     input int unsigned target);
    int unsigned start;
    int unsigned pick;
    write_page_count(count);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct   = 85;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct   = 0;
        recv_stall_pct = 85;
      end
      default: begin
        send_gap_pct   = 18;
        recv_stall_pct = 18;
      end
    endcase
    start = live_items;
    while (live_items - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        send_irq_program();
      else if (pick == 4)
        wait_for_results();
      else
        send_item(random_item());
    end
  endtask

  // Result receiver: ready changes at the falling edge.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result beat with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (mapper_results.size() == 0) begin
        report_mismatch("unexpected result beat, rom_address", out_ch.rom_address, 0);
      end else begin
        checked_want = mapper_results.pop_front();
        if (out_ch.irq_line !== checked_want.irq)
          report_mismatch("irq_line", out_ch.irq_line, checked_want.irq);
        if (out_ch.mirror_mode !== checked_want.mirror)
          report_mismatch("mirror_mode", out_ch.mirror_mode, checked_want.mirror);
        if (out_ch.rom_address !== checked_want.rom)
          report_mismatch("rom_address", out_ch.rom_address, checked_want.rom);
      end
    end
  end

  // Main sequence
  initial begin
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.operation       <= OP_WRITE;
    in_ch.address         <= '0;
    in_ch.value           <= '0;
    in_ch.tick_count      <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.prg_page_count <= PAGE_COUNT_RST;
    prg_sel[0] = PRG0_RST;
    prg_sel[1] = PRG1_RST;
    prg_sel[2] = PRG2_RST;
    for (int i = 0; i < 8; i++)
      chr_sel[i] = 8'h00;
    mirror_h   = 1'b0;
    irq_count  = 16'd0;
    latch_hi   = 8'h00;
    latch_lo   = 8'h00;
    irq_armed  = 1'b0;
    irq_flag   = 1'b0;
    tick_acc   = 2'd0;
    page_total = PAGE_COUNT_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_bank_windows();
    test_irq_counter();
    test_page_count_extremes();
    test_random_traffic(IDLE_NONE, 9'd256, 390);
    test_random_traffic(IDLE_SENDER, 9'd1, 390);
    test_random_traffic(IDLE_RECEIVER, 9'($urandom_range(0, 511)), 390);
    test_random_traffic(IDLE_BOTH, 9'($urandom_range(1, 256)), 390);
    wait_for_results();

    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
